FILE: rtl/tlv_record_parser_unit_macros.svh
// Assertion macros used by the TLV record parser front end.
`ifndef TLV_RECORD_PARSER_UNIT_MACROS_SVH
`define TLV_RECORD_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define TLVP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TLVP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TLVP_ASSERT(name, prop, msg)
`define TLVP_ASSERT_NEVER(name, cond, msg)

`endif

`endif

FILE: rtl/tlvp_pkg.sv
// Types and constants for the TLV record parser.
package tlvp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam logic [7:0]  MAX_RECORDS_RESET   = 8'd3;

  // Configuration register indexes
  localparam logic REG_MAX_RECORDS = 1'b0;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_VALUE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TYPE,
    KIND_LEN_LO,
    KIND_LEN_HI,
    KIND_VALUE,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        done;
    logic        last;
    logic [7:0]  idx;
    logic [1:0]  status;
  } cmd_t;

endpackage

FILE: rtl/tlvp_front.sv
// Front end: tracks record framing and classifies each byte into a command.
`include "tlv_record_parser_unit_macros.svh"

module tlvp_front
  import tlvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] max_records,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] byte_value,
  input  logic       buffer_end,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  record_count, record_count_next;
  logic        error, error_next;

  logic        accept;
  logic        err_now;
  logic        done;
  logic [15:0] full_len;

  assign accept   = in_valid && in_ready;
  assign err_now  = error || (phase == PH_TYPE && record_count >= max_records);
  assign full_len = {byte_value, len_lo};

  // Next state
  always_comb begin
    phase_next        = phase;
    len_lo_next       = len_lo;
    bytes_left_next   = bytes_left;
    record_count_next = record_count;
    error_next        = err_now;
    done              = 1'b0;
    if (!err_now) begin
      unique case (phase)
        PH_TYPE: begin
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_next = byte_value;
          phase_next  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (full_len == 16'd0) begin
            done = 1'b1;
          end else begin
            bytes_left_next = full_len;
            phase_next      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          bytes_left_next = bytes_left - 16'd1;
          done            = (bytes_left == 16'd1);
        end
      endcase
      if (done) begin
        phase_next        = PH_TYPE;
        record_count_next = record_count + 8'd1;
      end
    end
    if (buffer_end) begin
      phase_next        = PH_TYPE;
      bytes_left_next   = 16'd0;
      record_count_next = 8'd0;
      error_next        = 1'b0;
    end
  end

  // Command for the back end
  always_comb begin
    cmd.data   = byte_value;
    cmd.last   = buffer_end;
    cmd.idx    = record_count;
    cmd.done   = done;
    cmd.status = STATUS_OK;
    if (err_now) begin
      cmd.kind   = KIND_ERROR;
      cmd.status = STATUS_TOO_MANY;
    end else begin
      unique case (phase)
        PH_TYPE:   cmd.kind = KIND_TYPE;
        PH_LEN_LO: cmd.kind = KIND_LEN_LO;
        PH_LEN_HI: cmd.kind = KIND_LEN_HI;
        PH_VALUE:  cmd.kind = KIND_VALUE;
      endcase
      if (buffer_end && !done) begin
        cmd.status = STATUS_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      len_lo       <= 8'd0;
      bytes_left   <= 16'd0;
      record_count <= 8'd0;
      error        <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      len_lo       <= len_lo_next;
      bytes_left   <= bytes_left_next;
      record_count <= record_count_next;
      error        <= error_next;
    end
  end

  `TLVP_ASSERT(a_error_sticky, error && !(accept && buffer_end) |=> error, "error flag dropped inside a buffer")
  `TLVP_ASSERT_NEVER(a_value_has_bytes, phase == PH_VALUE && bytes_left == 16'd0, "value phase with no bytes left")
  `TLVP_ASSERT(a_end_clears, accept && buffer_end |=> phase == PH_TYPE && record_count == 8'd0 && !error, "buffer end did not clear framing state")

endmodule

FILE: rtl/tlvp_queue.sv
// Small FIFO of commands between the front and back ends.
module tlvp_queue
  import tlvp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/tlvp_back.sv
// Back end: holds record type and length and drives the result register.
module tlvp_back
  import tlvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  record_type,
  output logic [15:0] record_length,
  output logic [7:0]  value_byte,
  output logic        value_valid,
  output logic        record_done,
  output logic [7:0]  record_index,
  output logic [1:0]  status,
  output logic        buffer_done
);

  logic [7:0]  cur_type, cur_type_next;
  logic [15:0] cur_len, cur_len_next;
  logic [7:0]  res_type;
  logic [15:0] res_len;
  logic [7:0]  res_byte;
  logic        res_vvalid;
  logic        take;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    cur_type_next = cur_type;
    cur_len_next  = cur_len;
    res_byte      = 8'd0;
    res_vvalid    = 1'b0;
    unique case (cmd.kind)
      KIND_TYPE: begin
        cur_type_next = cmd.data;
        cur_len_next  = 16'd0;
      end
      KIND_LEN_LO: cur_len_next = {8'd0, cmd.data};
      KIND_LEN_HI: cur_len_next = {cmd.data, cur_len[7:0]};
      KIND_VALUE: begin
        res_byte   = cmd.data;
        res_vvalid = 1'b1;
      end
      default: ;
    endcase
    res_type = cur_type_next;
    res_len  = cur_len_next;
    if (cmd.kind == KIND_ERROR) begin
      res_type = 8'd0;
      res_len  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_type  <= 8'd0;
      cur_len   <= 16'd0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        cur_type  <= cur_type_next;
        cur_len   <= cur_len_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      record_type   <= res_type;
      record_length <= res_len;
      value_byte    <= res_byte;
      value_valid   <= res_vvalid;
      record_done   <= cmd.done;
      record_index  <= cmd.idx;
      status        <= cmd.status;
      buffer_done   <= cmd.last;
    end
  end

endmodule

FILE: rtl/tlv_record_parser_unit.sv
// Top level of the TLV record parser: config register, front end, queue, back end.
//
//   channel   dir  handshake            payload
//   in        in   in_valid/in_ready    byte_value, buffer_end
//   out       out  out_valid/out_ready  record_type, record_length, value_byte,
//                                       value_valid, record_done, record_index,
//                                       status, buffer_done
//   config    in   APB psel/penable     paddr, pwrite, pwdata, prdata, pready
//
// One byte per clock while the output keeps up: the front end classifies a byte
// in the cycle it is accepted, the command is registered in the queue, and the
// back end registers its result when it takes that entry from the queue.
// Synchronous active-high reset clears framing state, the queue and out_valid;
// max_records returns to 3.
// An output stall fills the queue; in_ready drops only once the queue is full.
module tlv_record_parser_unit
  import tlvp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        buffer_end,
  // Result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  record_type,
  output logic [15:0] record_length,
  output logic [7:0]  value_byte,
  output logic        value_valid,
  output logic        record_done,
  output logic [7:0]  record_index,
  output logic [1:0]  status,
  output logic        buffer_done
);

  logic [7:0] max_records;
  logic       reg_index;
  logic       cfg_write;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Register index comes from the word address; writes past the list are dropped.
  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_records <= MAX_RECORDS_RESET;
    end else if (cfg_write && reg_index == REG_MAX_RECORDS) begin
      max_records <= pwdata[7:0];
    end
  end

  // Read back the register; anything past the list reads as zero.
  always_comb begin
    prdata = 32'd0;
    if (reg_index == REG_MAX_RECORDS) begin
      prdata = {24'd0, max_records};
    end
  end

  // Classify each accepted byte; the front end advances only on a transaction.
  tlvp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .max_records (max_records),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_value  (byte_value),
    .buffer_end  (buffer_end),
    .cmd         (front_cmd)
  );

  // Hold commands while the output side stalls; its free space sets in_ready.
  tlvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Build the result fields and drive the output register.
  tlvp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (back_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_type   (record_type),
    .record_length (record_length),
    .value_byte    (value_byte),
    .value_valid   (value_valid),
    .record_done   (record_done),
    .record_index  (record_index),
    .status        (status),
    .buffer_done   (buffer_done)
  );

endmodule

FILE: tb/sv/tlv_record_parser_checker.sv
// Checker that predicts and compares every result of the TLV record parser.
`timescale 1ns / 1ps

module tlv_record_parser_checker
  import tlvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        buffer_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  record_type,
  input  logic [15:0] record_length,
  input  logic [7:0]  value_byte,
  input  logic        value_valid,
  input  logic        record_done,
  input  logic [7:0]  record_index,
  input  logic [1:0]  status,
  input  logic        buffer_done,
  output int unsigned errors,
  output int unsigned outstanding
);

  localparam logic [2:0] ADDR_MAX_RECORDS = {REG_MAX_RECORDS, 2'b00};

  typedef struct packed {
    logic [7:0]  rtype;
    logic [15:0] rlen;
    logic [7:0]  vbyte;
    logic        vvalid;
    logic        done;
    logic [7:0]  idx;
    logic [1:0]  stat;
    logic        bend;
  } tlv_result_t;

  // Shadow of the register and of the framing state
  logic [7:0]  limit_q;
  phase_t      phase_q;
  logic [7:0]  type_q;
  logic [15:0] length_q;
  logic [15:0] left_q;
  logic [7:0]  count_q;
  logic [1:0]  err_q;

  tlv_result_t pending_results[$];
  int unsigned fail_total = 0;

  task automatic clear_framing();
    phase_q  = PH_TYPE;
    type_q   = '0;
    length_q = '0;
    left_q   = '0;
    count_q  = '0;
    err_q    = STATUS_OK;
  endtask

  task automatic predict_record_byte(input logic [7:0] b, input logic last,
                                     output tlv_result_t r);
    logic done;
    r = '0;
    done = 1'b0;
    r.idx = count_q;
    if (err_q == STATUS_OK && phase_q == PH_TYPE && count_q >= limit_q)
      err_q = STATUS_TOO_MANY;
    if (err_q == STATUS_OK) begin
      case (phase_q)
        PH_TYPE: begin
          type_q   = b;
          length_q = '0;
          phase_q  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_q = {8'h00, b};
          phase_q  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_q = {b, length_q[7:0]};
          if (length_q == 16'd0) begin
            done = 1'b1;
          end else begin
            left_q  = length_q;
            phase_q = PH_VALUE;
          end
        end
        default: begin
          r.vbyte  = b;
          r.vvalid = 1'b1;
          left_q   = left_q - 16'd1;
          if (left_q == 16'd0)
            done = 1'b1;
        end
      endcase
      if (done) begin
        phase_q = PH_TYPE;
        count_q = count_q + 8'd1;
      end
      if (last && phase_q != PH_TYPE)
        r.stat = STATUS_TRUNCATED;
      r.rtype = type_q;
      r.rlen  = length_q;
    end else begin
      r.stat = STATUS_TOO_MANY;
    end
    r.done = done;
    r.bend = last;
    if (last)
      clear_framing();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tlv_result_t want;
    tlv_result_t next;
    if (rst) begin
      limit_q = MAX_RECORDS_RESET;
      clear_framing();
      pending_results.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_MAX_RECORDS) begin
        if (pwrite)
          limit_q = pwdata[7:0];
        else
          check_field("prdata", {24'h0, limit_q}, prdata);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          check_field("record_type", 32'(want.rtype), 32'(record_type));
          check_field("record_length", 32'(want.rlen), 32'(record_length));
          check_field("value_byte", 32'(want.vbyte), 32'(value_byte));
          check_field("value_valid", 32'(want.vvalid), 32'(value_valid));
          check_field("record_done", 32'(want.done), 32'(record_done));
          check_field("record_index", 32'(want.idx), 32'(record_index));
          check_field("status", 32'(want.stat), 32'(status));
          check_field("buffer_done", 32'(want.bend), 32'(buffer_done));
        end
      end
      if (in_valid && in_ready) begin
        predict_record_byte(byte_value, buffer_end, next);
        pending_results.push_back(next);
      end
    end
    errors      <= fail_total;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_tlv_record_parser_unit.sv
// Top of the TLV record parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_tlv_record_parser_unit
  import tlvp_pkg::*;
;

  localparam logic [2:0]  ADDR_MAX_RECORDS = {REG_MAX_RECORDS, 2'b00};
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PHASE_BYTES      = 64;
  localparam int unsigned PHASE_COUNT      = 5;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = '0;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  record_type;
  logic [15:0] record_length;
  logic [7:0]  value_byte;
  logic        value_valid;
  logic        record_done;
  logic [7:0]  record_index;
  logic [1:0]  status;
  logic        buffer_done;

  int unsigned check_errors;
  int unsigned results_pending;

  // Idling controls for the sender and the receiver
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          long_hold_req = 1'b0;

  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned limits_used = 0;
  logic [7:0]  frame_bytes[$];

  tlv_record_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_value    (byte_value),
    .buffer_end    (buffer_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_type   (record_type),
    .record_length (record_length),
    .value_byte    (value_byte),
    .value_valid   (value_valid),
    .record_done   (record_done),
    .record_index  (record_index),
    .status        (status),
    .buffer_done   (buffer_done)
  );

  tlv_record_parser_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_value    (byte_value),
    .buffer_end    (buffer_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_type   (record_type),
    .record_length (record_length),
    .value_byte    (value_byte),
    .value_valid   (value_valid),
    .record_done   (record_done),
    .record_index  (record_index),
    .status        (status),
    .buffer_done   (buffer_done),
    .errors        (check_errors),
    .outstanding   (results_pending)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the handshakes ever stop moving.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tlv_record_parser_unit regression: fail");
      $finish;
    end
  end

  // Receiver: mix short stalls with ready stretches; honor a long hold-off
  // on request so the parser's queue fills and in_ready drops.
  initial begin
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Drive one APB transaction: setup cycle, access until pready, then idle with
  // the port released.
  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_MAX_RECORDS;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has drained, then let
  // the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the record limit with random upper bits, then read it back.
  task automatic set_record_limit(input logic [7:0] limit);
    wait_idle();
    apb_access(1'b1, {24'($urandom_range(0, 16777215)), limit});
    apb_access(1'b0, 32'h0);
    limits_used++;
  endtask

  // Offer one byte transaction, with an optional random gap ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    buffer_end <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send the staged buffer, marking its final byte.
  task automatic send_frame();
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // Mostly short values; now and then a length whose high byte is set.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(3, 12);
    if (r < 99) return $urandom_range(13, 40);
    return $urandom_range(256, 270);
  endfunction

  // Stage the first keep bytes of a record: type, length low, length high,
  // then random values.
  task automatic add_record(input int unsigned len, input int unsigned keep);
    logic [15:0] l;
    l = len[15:0];
    for (int unsigned i = 0; i < keep; i++) begin
      case (i)
        0:       frame_bytes.push_back(8'($urandom));
        1:       frame_bytes.push_back(l[7:0]);
        2:       frame_bytes.push_back(l[15:8]);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  // Build one random buffer: well-formed records most of the time, then
  // truncated buffers, plain noise and buffers past the record limit.
  task automatic build_frame(input int unsigned limit);
    int unsigned kind;
    int unsigned n;
    int unsigned len;
    int unsigned max_keep;
    frame_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9 && limit > 6)
      kind = 0;
    if (kind <= 5) begin
      n = $urandom_range(1, (limit < 5) ? limit : 5);
      repeat (n) begin
        len = pick_length();
        add_record(len, len + 3);
      end
    end else if (kind <= 7) begin
      repeat ($urandom_range(0, 2)) begin
        len = pick_length();
        add_record(len, len + 3);
      end
      len = $urandom_range(0, 1) ? $urandom_range(0, 65535) : pick_length();
      max_keep = (len + 2 < 6) ? len + 2 : 6;
      add_record(len, $urandom_range(1, max_keep));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat (limit + $urandom_range(1, 2)) begin
        len = $urandom_range(0, 4);
        add_record(len, len + 3);
      end
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    int unsigned quota;
    int unsigned limit;
    bit          paused;

    // Hold reset, then release it at a clock edge.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed buffers under the reset limit of three records: a zero-length
    // record, single and double value records, then a fourth record that
    // trips the limit and a trailing byte that is ignored.
    frame_bytes = '{8'hFF, 8'h00, 8'h00,
                    8'h00, 8'h01, 8'h00, 8'hFF,
                    8'h5A, 8'h02, 8'h00, 8'h00, 8'hA5,
                    8'h7E, 8'h11};
    send_frame();
    // Truncate a record declared with the largest length.
    frame_bytes = '{8'h80, 8'hFF, 8'hFF, 8'h01, 8'h02};
    send_frame();
    // Truncate right after the type byte.
    frame_bytes = '{8'hC3};
    send_frame();
    // End the buffer exactly on the last value byte.
    frame_bytes = '{8'h12, 8'h01, 8'h00, 8'h34};
    send_frame();
    // A limit of zero turns every record into an over-limit record.
    set_record_limit(8'd0);
    frame_bytes = '{8'h42};
    send_frame();

    // Random phases, each under its own record limit.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       limit = 255;
        1:       limit = 1;
        2:       limit = $urandom_range(2, 6);
        3:       limit = $urandom_range(1, 255);
        default: limit = 32'(MAX_RECORDS_RESET);
      endcase
      set_record_limit(limit[7:0]);

      // Walk the record index to its top: 256 zero-length records against
      // the largest limit, the last one over the limit.
      if (p == 0) begin
        frame_bytes.delete();
        repeat (256) add_record(0, 3);
        send_frame();
      end

      // Hold off the receiver for a long stretch while bytes keep coming.
      if (p == 2)
        long_hold_req = 1'b1;

      // Run the final phase with no idling on either side.
      if (p == PHASE_COUNT - 1) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end

      quota  = bytes_sent + PHASE_BYTES;
      paused = 1'b0;
      while (bytes_sent < quota) begin
        build_frame(limit);
        send_frame();
        // Pause the sender once mid-phase until every result is back.
        if (p == 3 && !paused && bytes_sent >= quota - PHASE_BYTES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    // Drain the pipeline and let the tail settle.
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d buffers under %0d record limits.",
             bytes_sent, frames_sent, limits_used);
    $display("Included over-limit, truncated, long-length and noise buffers.");
    if (check_errors == 0 && results_pending == 0) begin
      $display("tlv_record_parser_unit regression: pass");
    end else begin
      if (results_pending != 0)
        $error("%0d predicted results never arrived", results_pending);
      $display("tlv_record_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
